FILE: rtl/unsigned_decimal_field_formatter_defines.svh
// Assertion macros for the unsigned decimal field formatter.
// Included by files that carry concurrent checks; the bodies are empty for synthesis.
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define UDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udf check failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define UDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("udf check failed: next-cycle implication");

`else

`define UDF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define UDF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/udf_pkg.sv
// Shared types and constants for the unsigned decimal field formatter.
// No dependencies; used by udf_div10 and the top level.
package udf_pkg;

   localparam int VALUE_W     = 32;
   localparam int FIELD_IN_W  = 7;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   // A 32-bit value has at most ten decimal digits.
   localparam int NDIG      = 10;
   localparam int DIG_IDX_W = 4;

   typedef logic [DIG_IDX_W-1:0] digit_cnt_type;
   typedef logic [3:0]           digit_type;

   // Divide by ten as a multiply by the rounded-up reciprocal 2^35 / 10.
   localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
   localparam int                 DIV10_SHIFT = 35;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [VALUE_W-1:0] quotient;
      digit_type          remainder;
   } div10_result_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_PLAN    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

endpackage

FILE: rtl/udf_div10.sv
// Shared divide-by-ten unit: quotient by reciprocal multiply, remainder from low bits.
// Depends on udf_pkg.
module udf_div10
   import udf_pkg::*;
(
   input  logic [VALUE_W-1:0] dividend,
   output div10_result_type   result
);

   logic [2*VALUE_W-1:0] product;
   logic [VALUE_W-1:0]   quot;
   logic [3:0]           quot_x10_low;

   assign product = {{VALUE_W{1'b0}}, dividend} * {{VALUE_W{1'b0}}, DIV10_MAGIC};
   assign quot    = VALUE_W'(product >> DIV10_SHIFT);

   // The remainder is below ten, so four bits of dividend - 10*q are enough.
   assign quot_x10_low = {quot[0], 3'b000} + {quot[2:0], 1'b0};

   assign result.quotient  = quot;
   assign result.remainder = dividend[3:0] - quot_x10_low;

endmodule

FILE: rtl/unsigned_decimal_field_formatter.sv
// Top level of the unsigned decimal field formatter ("%u" style conversion).
// Depends on udf_pkg, udf_div10 and unsigned_decimal_field_formatter_defines.svh.
//
// Usage
//   The req_ stream takes one word per field: a 32-bit unsigned value plus the
//   width, precision and flag bits. The rsp_ stream returns the formatted field
//   as ASCII, one character per word, with rsp_tlast on the final character.
//   A field that comes out empty (zero value, zero precision, no width) returns
//   no words at all.
//   Timing: after a word is accepted, the shared divide-by-ten unit produces one
//   digit per cycle, a planning state then works out the padding, and then one
//   character leaves per cycle while rsp_tready is high.
//   req_tready is high only while the sequencer is idle. The final character
//   sits in the output register, so the next word can be accepted and converted
//   while that character still waits for the receiver.
//   When the receiver stalls, the current character is held in the output
//   register and the sequencer waits; nothing is dropped.
//   Reset (synchronous, active high) returns the sequencer to idle and clears
//   rsp_tvalid; a field in progress is abandoned.
`include "unsigned_decimal_field_formatter_defines.svh"

module unsigned_decimal_field_formatter
   import udf_pkg::*;
#(
   parameter int MAX_FIELD = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0 up: value[31:0], field_width[38:32], precision[45:39],
   // has_precision[46], zero_pad[47], left_align[48], zero fill [55:49].
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0 up: character[7:0].
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   // Counts of characters range up to MAX_FIELD.
   localparam int CNT_W = $clog2(MAX_FIELD + 1);

   // Unpacked request fields.
   logic [VALUE_W-1:0]    in_value;
   logic [FIELD_IN_W-1:0] in_width;
   logic [FIELD_IN_W-1:0] in_prec;
   logic                  in_dot;
   logic                  in_zpad;
   logic                  in_left;

   assign in_value = req_tdata[31:0];
   assign in_width = req_tdata[38:32];
   assign in_prec  = req_tdata[45:39];
   assign in_dot   = req_tdata[46];
   assign in_zpad  = req_tdata[47];
   assign in_left  = req_tdata[48];

   // Sequencer and item registers.
   state_type          state_ff,  state_in;
   logic [VALUE_W-1:0] value_ff,  value_in;
   logic [CNT_W-1:0]   width_ff,  width_in;
   logic [CNT_W-1:0]   prec_ff,   prec_in;
   logic               dot_ff,    dot_in;
   logic               left_ff,   left_in;
   logic               zchar_ff,  zchar_in;
   digit_cnt_type      ndig_ff,   ndig_in;
   digit_type          digits_ff [NDIG];
   logic               digit_we;
   logic [CNT_W-1:0]   pad_ff,    pad_in;
   logic [CNT_W-1:0]   lead_ff,   lead_in;
   logic [CNT_W-1:0]   total_ff,  total_in;
   digit_cnt_type      dig_ff,    dig_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff,  rsp_char_in;
   logic       rsp_last_ff,  rsp_last_in;

   logic                  accept;
   logic                  load_out;
   div10_result_type      div_res;
   logic [CNT_W-1:0]      ndig_ext;
   logic [CNT_W-1:0]      body_len;
   logic [CNT_W-1:0]      lead_calc;
   logic [CNT_W-1:0]      pad_calc;
   logic [7:0]            pad_char;
   digit_cnt_type         rd_idx;

   udf_div10 u_div10 (
      .dividend (value_ff),
      .result   (div_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // Padding and leading-zero counts once the digit count is known.
   assign ndig_ext  = CNT_W'(ndig_ff);
   assign lead_calc = (dot_ff && (prec_ff > ndig_ext)) ? (prec_ff - ndig_ext) : '0;
   assign body_len  = ndig_ext + lead_calc;
   assign pad_calc  = (width_ff > body_len) ? (width_ff - body_len) : '0;

   assign pad_char = zchar_ff ? CH_ZERO : CH_SPACE;
   assign rd_idx   = dig_ff - digit_cnt_type'(1);

   always_comb begin
      state_in  = state_ff;
      value_in  = value_ff;
      width_in  = width_ff;
      prec_in   = prec_ff;
      dot_in    = dot_ff;
      left_in   = left_ff;
      zchar_in  = zchar_ff;
      ndig_in   = ndig_ff;
      digit_we  = 1'b0;
      pad_in    = pad_ff;
      lead_in   = lead_ff;
      total_in  = total_ff;
      dig_in    = dig_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = in_value;
               // Width and precision saturate at the largest field.
               width_in = (in_width > FIELD_IN_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                              : CNT_W'(in_width);
               prec_in  = (in_prec > FIELD_IN_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD)
                                                             : CNT_W'(in_prec);
               dot_in   = in_dot;
               left_in  = in_left;
               // '0' padding only applies right-aligned without a precision.
               zchar_in = in_zpad && !in_left && !in_dot;
               ndig_in  = '0;
               // A zero printed at precision zero has no digits at all.
               if ((in_value == '0) && in_dot && (in_prec == '0)) begin
                  state_in = ST_PLAN;
               end else begin
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            digit_we = 1'b1;
            ndig_in  = ndig_ff + digit_cnt_type'(1);
            value_in = div_res.quotient;
            if ((div_res.quotient == '0) || (ndig_ff == digit_cnt_type'(NDIG - 1))) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            lead_in  = lead_calc;
            pad_in   = pad_calc;
            total_in = pad_calc + body_len;
            dig_in   = ndig_ff;
            if ((pad_calc + body_len) == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (total_ff == CNT_W'(1));
               total_in     = total_ff - CNT_W'(1);
               if (!left_ff && (pad_ff != '0)) begin
                  rsp_char_in = pad_char;
                  pad_in      = pad_ff - CNT_W'(1);
               end else if (lead_ff != '0) begin
                  rsp_char_in = CH_ZERO;
                  lead_in     = lead_ff - CNT_W'(1);
               end else if (dig_ff != '0) begin
                  rsp_char_in = CH_ZERO | {4'b0000, digits_ff[rd_idx]};
                  dig_in      = rd_idx;
               end else begin
                  rsp_char_in = pad_char;
                  pad_in      = pad_ff - CNT_W'(1);
               end
               if (total_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      width_ff    <= width_in;
      prec_ff     <= prec_in;
      dot_ff      <= dot_in;
      left_ff     <= left_in;
      zchar_ff    <= zchar_in;
      ndig_ff     <= ndig_in;
      pad_ff      <= pad_in;
      lead_ff     <= lead_in;
      total_ff    <= total_in;
      dig_ff      <= dig_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (digit_we) begin
         digits_ff[ndig_ff] <= div_res.remainder;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // An accepted word always starts a conversion or goes straight to planning.
   `UDF_ASSERT_NEXT(a_accept_starts, clock, reset, accept, (state_ff == ST_CONVERT) || (state_ff == ST_PLAN))
   // The digit store never overflows while converting.
   `UDF_ASSERT_IMPL(a_digit_bound, clock, reset, state_ff == ST_CONVERT, ndig_ff < digit_cnt_type'(NDIG))
   // The emitter never runs with nothing left to send.
   `UDF_ASSERT_IMPL(a_emit_nonempty, clock, reset, state_ff == ST_EMIT, total_ff != '0)

endmodule
